### src/rsk_pkg.sv
// Package: record, payload, key and state types for the record sorter
`timescale 1ns / 1ps
package rsk_pkg;

  localparam int KeyW = 160;

  typedef enum logic [1:0] {
    MODE_ORDER = 2'd0,
    MODE_NAME  = 2'd1,
    MODE_LIT   = 2'd2,
    MODE_POP   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [63:0] name_bytes_first;
    logic [63:0] name_bytes_middle;
    logic [31:0] name_bytes_final;
    logic [30:0] head_count;
    logic [13:0] literate_share;
    logic        batch_end;
  } in_t;

  typedef struct packed {
    logic [63:0] out_name_first;
    logic [63:0] out_name_middle;
    logic [31:0] out_name_final;
    logic [30:0] out_head_count;
    logic [13:0] out_literate_share;
    logic        run_end;
    logic        overflow_seen;
  } out_t;

  typedef struct packed {
    logic [63:0] name_first;
    logic [63:0] name_middle;
    logic [31:0] name_final;
    logic [30:0] head_count;
    logic [13:0] literate_share;
  } rec_t;

  typedef logic [KeyW-1:0] key_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_EMIT  = 2'd3
  } state_t;

  function automatic key_t key_of(input rec_t r, input mode_t m);
    key_t k;
    k = '0;
    case (m)
      MODE_NAME: k = {r.name_first, r.name_middle, r.name_final};
      MODE_LIT:  k = {{(KeyW - 14){1'b0}}, r.literate_share};
      MODE_POP:  k = {{(KeyW - 31){1'b0}}, r.head_count};
      default:   k = '0;
    endcase
    return k;
  endfunction

endpackage

### src/rsk_ram.sv
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
module rsk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/record_sort_by_key_core.sv
// Top level: loads a batch of records into RAM and emits them sorted by key
// Order: after the batch-end record, the RAM is scanned once per result (SCAN,
// then DRAIN for the last read), and the result is held in EMIT until taken.
// Throughput: one record per cycle while loading; emission costs one full RAM
// scan per result, and no new record is taken until the batch has drained.
// Reset: synchronous, active low; clears count, drop flag, mode and FSM.
`timescale 1ns / 1ps
module record_sort_by_key_core #(
  parameter int RECORDS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsk_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rsk_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata
);
  localparam int AW = $clog2(RECORDS);
  localparam int CW = $clog2(RECORDS + 1);

  rsk_pkg::state_t state_r, state_nxt;
  rsk_pkg::mode_t  mode_r;
  logic [CW-1:0]   cnt_r, rank_r;
  logic            drop_r;
  logic [AW-1:0]   scan_r;
  logic            rd_vld_r;
  logic [AW-1:0]   rd_idx_r;
  rsk_pkg::rec_t   rd_rec, wr_rec, best_rec_r;
  rsk_pkg::key_t   best_key_r, prev_key_r, rd_key;
  logic [AW-1:0]   best_idx_r, prev_idx_r;
  logic            best_vld_r, prev_vld_r;
  logic            in_xfer, out_xfer, full, last_scan, gt_prev, lt_best, take;

  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign full      = (cnt_r == CW'(RECORDS));
  assign last_scan = (scan_r == AW'(cnt_r - CW'(1)));

  assign wr_rec = '{name_first: in_data.name_bytes_first,
                    name_middle: in_data.name_bytes_middle,
                    name_final: in_data.name_bytes_final,
                    head_count: in_data.head_count,
                    literate_share: in_data.literate_share};

  rsk_ram #(.WIDTH($bits(rsk_pkg::rec_t)), .DEPTH(RECORDS)) u_ram (
    .clk   (clk),
    .we    (in_xfer && !full),
    .waddr (cnt_r[AW-1:0]),
    .wdata (wr_rec),
    .raddr (scan_r),
    .rdata (rd_rec)
  );

  assign rd_key  = rsk_pkg::key_of(rd_rec, mode_r);
  assign gt_prev = !prev_vld_r || (rd_key > prev_key_r) ||
                   (rd_key == prev_key_r && rd_idx_r > prev_idx_r);
  assign lt_best = !best_vld_r || (rd_key < best_key_r) ||
                   (rd_key == best_key_r && rd_idx_r < best_idx_r);
  assign take    = rd_vld_r && gt_prev && lt_best;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsk_pkg::ST_LOAD:  if (in_xfer && in_data.batch_end) state_nxt = rsk_pkg::ST_SCAN;
      rsk_pkg::ST_SCAN:  if (last_scan) state_nxt = rsk_pkg::ST_DRAIN;
      rsk_pkg::ST_DRAIN: state_nxt = rsk_pkg::ST_EMIT;
      rsk_pkg::ST_EMIT: begin
        if (out_xfer) begin
          state_nxt = (rank_r == CW'(cnt_r - CW'(1))) ? rsk_pkg::ST_LOAD : rsk_pkg::ST_SCAN;
        end
      end
      default:           state_nxt = rsk_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == rsk_pkg::ST_LOAD);
    out_valid = (state_r == rsk_pkg::ST_EMIT);
    out_data  = '{out_name_first: best_rec_r.name_first,
                  out_name_middle: best_rec_r.name_middle,
                  out_name_final: best_rec_r.name_final,
                  out_head_count: best_rec_r.head_count,
                  out_literate_share: best_rec_r.literate_share,
                  run_end: (rank_r == CW'(cnt_r - CW'(1))),
                  overflow_seen: drop_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rsk_pkg::ST_LOAD;
      mode_r     <= rsk_pkg::MODE_ORDER;
      cnt_r      <= '0;
      rank_r     <= '0;
      drop_r     <= 1'b0;
      scan_r     <= '0;
      rd_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
      prev_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == rsk_pkg::ST_SCAN);
      if (cfg_we) begin
        mode_r <= rsk_pkg::mode_t'(cfg_wdata);
      end
      if (in_xfer) begin
        if (full) begin
          drop_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
      if (state_r == rsk_pkg::ST_SCAN) begin
        scan_r <= last_scan ? '0 : scan_r + AW'(1);
      end
      if (out_xfer) begin
        best_vld_r <= 1'b0;
      end else if (take) begin
        best_vld_r <= 1'b1;
      end
      if (out_xfer) begin
        if (rank_r == CW'(cnt_r - CW'(1))) begin
          cnt_r      <= '0;
          rank_r     <= '0;
          drop_r     <= 1'b0;
          prev_vld_r <= 1'b0;
        end else begin
          rank_r     <= rank_r + CW'(1);
          prev_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_r;
    if (take) begin
      best_rec_r <= rd_rec;
      best_key_r <= rd_key;
      best_idx_r <= rd_idx_r;
    end
    if (out_xfer) begin
      prev_key_r <= best_key_r;
      prev_idx_r <= best_idx_r;
    end
  end
endmodule

### src/rsk_checker.sv
// Port checker for the record sorter, bound to the top level
`timescale 1ns / 1ps
module rsk_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input rsk_pkg::out_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("load and emit overlap");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.run_end |=> !out_valid && in_ready)
    else $error("batch end did not return to load");

  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("ready dropped without a transfer");
endmodule

bind record_sort_by_key_core rsk_checker u_rsk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### test/tb.sv
// Testbench for record_sort_by_key_core: random batches checked against a sorting scoreboard
`timescale 1ns / 1ps
module tb;

  localparam int Slots = 8;
  localparam int CycleLimit = 400000;

  class sort_board;
    rsk_pkg::rec_t  held[$];
    bit             dropped;
    rsk_pkg::mode_t key_mode;
    rsk_pkg::out_t  pending[$];
    int             errors;
    int             checked;

    function bit key_greater(rsk_pkg::rec_t a, rsk_pkg::rec_t b);
      case (key_mode)
        rsk_pkg::MODE_NAME: return {a.name_first, a.name_middle, a.name_final} >
                                   {b.name_first, b.name_middle, b.name_final};
        rsk_pkg::MODE_LIT:  return a.literate_share > b.literate_share;
        rsk_pkg::MODE_POP:  return a.head_count > b.head_count;
        default:            return 1'b0;
      endcase
    endfunction

    function void note_load(rsk_pkg::in_t d);
      rsk_pkg::rec_t r;
      rsk_pkg::rec_t sorted[$];
      int k;
      rsk_pkg::out_t o;
      r = '{d.name_bytes_first, d.name_bytes_middle, d.name_bytes_final,
            d.head_count, d.literate_share};
      if (held.size() < Slots) held.push_back(r);
      else dropped = 1'b1;
      if (!d.batch_end) return;
      foreach (held[i]) begin
        k = sorted.size();
        while (k > 0 && key_greater(sorted[k-1], held[i])) k--;
        sorted.insert(k, held[i]);
      end
      foreach (sorted[i]) begin
        o = '{sorted[i].name_first, sorted[i].name_middle, sorted[i].name_final,
              sorted[i].head_count, sorted[i].literate_share,
              i == sorted.size() - 1, dropped};
        pending.push_back(o);
      end
      held.delete();
      dropped = 1'b0;
    endfunction

    function void check_emit(rsk_pkg::out_t a);
      rsk_pkg::out_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected transfer %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.out_name_first !== e.out_name_first) begin
        $error("out_name_first exp %h got %h", e.out_name_first, a.out_name_first); errors++;
      end
      if (a.out_name_middle !== e.out_name_middle) begin
        $error("out_name_middle exp %h got %h", e.out_name_middle, a.out_name_middle); errors++;
      end
      if (a.out_name_final !== e.out_name_final) begin
        $error("out_name_final exp %h got %h", e.out_name_final, a.out_name_final); errors++;
      end
      if (a.out_head_count !== e.out_head_count) begin
        $error("out_head_count exp %0d got %0d", e.out_head_count, a.out_head_count); errors++;
      end
      if (a.out_literate_share !== e.out_literate_share) begin
        $error("out_literate_share exp %0d got %0d", e.out_literate_share,
               a.out_literate_share); errors++;
      end
      if (a.run_end !== e.run_end) begin
        $error("run_end exp %0d got %0d", e.run_end, a.run_end); errors++;
      end
      if (a.overflow_seen !== e.overflow_seen) begin
        $error("overflow_seen exp %0d got %0d", e.overflow_seen, a.overflow_seen); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, cfg_we = 0;
  logic [1:0] cfg_wdata = '0;
  rsk_pkg::in_t in_data = '0;
  rsk_pkg::out_t out_data;
  sort_board board;
  int cycles = 0, sent = 0, batches = 0;
  bit calm = 0;

  always #5 clk = ~clk;

  record_sort_by_key_core #(.RECORDS(Slots)) u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_wdata
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && in_ready) board.note_load(in_data);
    if (rst_n && out_valid && out_ready) board.check_emit(out_data);
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, none in the calm tail
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(negedge clk);
    end
  end

  task automatic send(rsk_pkg::in_t d);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 11);
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
    if (d.batch_end) batches++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (Slots * (Slots + 4)) @(negedge clk);
  endtask

  task automatic set_mode(rsk_pkg::mode_t m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.key_mode = m;
  endtask

  function automatic rsk_pkg::in_t rand_rec(bit last, bit dup);
    rsk_pkg::in_t d;
    d.name_bytes_first  = {$urandom, $urandom};
    d.name_bytes_middle = {$urandom, $urandom};
    d.name_bytes_final  = $urandom;
    d.head_count        = 31'($urandom);
    d.literate_share    = $urandom_range(0, 3) == 0 ? 14'($urandom)
                                                    : 14'($urandom_range(0, 10000));
    if (dup) begin
      d.name_bytes_first  = {8'h41 + 8'($urandom_range(0, 2)), 56'h0};
      d.name_bytes_middle = $urandom_range(0, 1) ? '0 : '1;
      d.name_bytes_final  = '0;
      d.head_count        = 31'($urandom_range(0, 3));
      d.literate_share    = 14'($urandom_range(0, 2) * 5000);
    end
    d.batch_end = last;
    return d;
  endfunction

  task automatic batch(int len, bit dup);
    for (int i = 0; i < len; i++) send(rand_rec(i == len - 1, dup));
  endtask

  initial begin
    rsk_pkg::in_t d;
    board = new();
    board.key_mode = rsk_pkg::MODE_ORDER;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: field extremes, single record, overflow, every mode
    d = '1;
    send(d);
    d = '0; d.batch_end = 1'b1;
    send(d);
    set_mode(rsk_pkg::MODE_NAME);
    d = '1; d.batch_end = 1'b0; send(d);
    d = '0; send(d);
    d = '0; d.name_bytes_final = 32'h1; send(d);
    d = '0; d.name_bytes_first = 64'h8000_0000_0000_0000; d.batch_end = 1'b1; send(d);
    set_mode(rsk_pkg::MODE_LIT);
    d = '0; d.literate_share = 14'd10000; d.batch_end = 1'b1; send(d);
    set_mode(rsk_pkg::MODE_POP);
    batch(Slots + 3, 1'b1);
    set_mode(rsk_pkg::MODE_ORDER);
    batch(Slots, 1'b0);
    while (sent < 230) begin
      if (sent > 200) calm = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0)
        set_mode(rsk_pkg::mode_t'($urandom_range(0, 3)));
      batch($urandom_range(0, 4) == 0 ? $urandom_range(Slots, Slots + 3)
                                      : $urandom_range(1, Slots), 1'($urandom_range(0, 1)));
    end
    drain();
    $display("tb: %0d records in %0d batches, %0d sorted records checked, all four keys",
             sent, batches, board.checked);
    if (board.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
